FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/cld_pkg.sv
package cld_pkg;

  // Field widths.
  localparam int COORD_BITS     = 16;
  localparam int ANGLE_BITS     = 32;
  localparam int RADIUS_BITS    = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // Internal widths: coordinate difference, its magnitude, cable length,
  // square root radicand and partial remainder.
  localparam int DIFF_BITS = COORD_BITS + 2;
  localparam int MAG_BITS  = COORD_BITS + 1;
  localparam int LEN_BITS  = COORD_BITS + 2;
  localparam int RAD_BITS  = 2 * LEN_BITS;
  localparam int REM_BITS  = LEN_BITS + 2;

  // Angle scale factor and the bits it adds to a length difference.
  localparam int ANGLE_SCALE = 100;
  localparam int SCALE_BITS  = 7;

  // Register reset values.
  localparam logic signed [COORD_BITS-1:0] LEFT_X_RESET  = 16'sd3040;
  localparam logic signed [COORD_BITS-1:0] LEFT_Y_RESET  = 16'sd2560;
  localparam logic signed [COORD_BITS-1:0] RIGHT_X_RESET = -16'sd3040;
  localparam logic signed [COORD_BITS-1:0] RIGHT_Y_RESET = 16'sd2560;
  localparam logic [RADIUS_BITS-1:0]       RADIUS_RESET  = 16'd320;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEFT_X,
    CFG_LEFT_Y,
    CFG_RIGHT_X,
    CFG_RIGHT_Y,
    CFG_RADIUS
  } cfg_reg_t;

  // One trajectory point request.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         first_point;
  } in_item_t;

  // One pair of motor angle steps.
  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] left_angle;
    logic signed [ANGLE_BITS-1:0] right_angle;
    logic                         saturated;
  } out_item_t;

  // Phase strobes from the sequencer to each cable lane.
  typedef struct packed {
    logic load;
    logic sq_step;
    logic root_step;
    logic delta;
    logic scale;
    logic div_step;
  } lane_ctrl_t;

  // Width of the rounding division numerator 2*m + r.
  function automatic int num_bits(int frac_bits);
    return LEN_BITS + SCALE_BITS + frac_bits + 2;
  endfunction

  // The divider retires two quotient bits per cycle.
  function automatic int div_cycles(int frac_bits);
    return (num_bits(frac_bits) + 1) >> 1;
  endfunction

  // Sign-extend a coordinate to the difference width.
  function automatic logic signed [DIFF_BITS-1:0] sext_coord(logic [COORD_BITS-1:0] v);
    return {{(DIFF_BITS - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

endpackage

FILE: rtl/core/cld_lane.sv
`include "assert_macros.svh"

module cld_lane #(
  parameter int ANGLE_FRACTION_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  cld_pkg::lane_ctrl_t                     ctrl,
  input  logic                                    flip,
  input  logic signed [cld_pkg::DIFF_BITS-1:0]    dx,
  input  logic signed [cld_pkg::DIFF_BITS-1:0]    dy,
  input  logic [cld_pkg::RADIUS_BITS-1:0]         radius,
  output logic signed [cld_pkg::ANGLE_BITS-1:0]   angle,
  output logic                                    sat
);

  localparam int MAG_BITS   = cld_pkg::MAG_BITS;
  localparam int LEN_BITS   = cld_pkg::LEN_BITS;
  localparam int RAD_BITS   = cld_pkg::RAD_BITS;
  localparam int REM_BITS   = cld_pkg::REM_BITS;
  localparam int SH_BITS    = REM_BITS + 2;
  localparam int ANGLE_BITS = cld_pkg::ANGLE_BITS;
  localparam int M_BITS     = LEN_BITS + cld_pkg::SCALE_BITS + ANGLE_FRACTION_BITS;
  localparam int NUM_PAD    = 2 * cld_pkg::div_cycles(ANGLE_FRACTION_BITS);
  localparam int DIV_BITS   = cld_pkg::RADIUS_BITS + 1;
  localparam int WIDE_BITS  = (NUM_PAD > ANGLE_BITS) ? NUM_PAD : ANGLE_BITS + 1;
  localparam logic [WIDE_BITS-1:0] POS_MAX = WIDE_BITS'((64'd1 << (ANGLE_BITS - 1)) - 64'd1);
  localparam logic [WIDE_BITS-1:0] NEG_MAX = WIDE_BITS'(64'd1 << (ANGLE_BITS - 1));

  logic [MAG_BITS-1:0] ax_r, ay_r, sx_r, sy_r;
  logic [RAD_BITS-1:0] acc_r, sq_nxt;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic [LEN_BITS-1:0] root_r, root_nxt, prev_r, dmag_r, dmag_nxt;
  logic                neg_r, neg_nxt;
  logic [NUM_PAD-1:0]  num_r, num_nxt, div_num_nxt, num_v;
  logic [DIV_BITS-1:0] drem_r, div_rem_nxt, drem_v, dvs;
  logic [DIV_BITS:0]   t_v;
  logic [SH_BITS-1:0]  rem_sh, trial;
  logic                root_fit;
  logic [LEN_BITS:0]   diff;
  logic [M_BITS-1:0]   m_w;
  logic [MAG_BITS-1:0] dx_mag, dy_mag;
  logic [WIDE_BITS-1:0] q_wide, q_clamp;
  logic                sat_pos, sat_neg;

  // Magnitudes of the coordinate differences.
  assign dx_mag = dx[cld_pkg::DIFF_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
  assign dy_mag = dy[cld_pkg::DIFF_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);

  // Both squares accumulate MSB first, one multiplier bit of each per cycle.
  assign sq_nxt = (acc_r << 1)
                + (sx_r[MAG_BITS-1] ? RAD_BITS'(ax_r) : '0)
                + (sy_r[MAG_BITS-1] ? RAD_BITS'(ay_r) : '0);

  // Square root: bring down two radicand bits and try the next root bit.
  assign rem_sh   = {rem_r, acc_r[RAD_BITS-1 -: 2]};
  assign trial    = SH_BITS'({root_r, 2'b01});
  assign root_fit = rem_sh >= trial;
  assign rem_nxt  = root_fit ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
  assign root_nxt = {root_r[LEN_BITS-2:0], root_fit};

  // Length change against the previous point and the sign of the angle.
  assign diff     = {1'b0, root_r} - {1'b0, prev_r};
  assign dmag_nxt = diff[LEN_BITS] ? LEN_BITS'(-diff) : LEN_BITS'(diff);
  assign neg_nxt  = flip ? (!diff[LEN_BITS] && diff != '0) : diff[LEN_BITS];

  // Rounding numerator 2*m + r, with m = |dl| * 100 scaled by the fraction bits.
  assign m_w     = (M_BITS'(dmag_r) * M_BITS'(cld_pkg::ANGLE_SCALE)) << ANGLE_FRACTION_BITS;
  assign num_nxt = NUM_PAD'({m_w, 1'b0}) + NUM_PAD'(radius);

  // Restoring division by 2*r, two quotient bits per cycle.
  always_comb begin
    dvs    = {radius, 1'b0};
    drem_v = drem_r;
    num_v  = num_r;
    t_v    = '0;
    for (int k = 0; k < 2; k++) begin
      t_v   = {drem_v, num_v[NUM_PAD-1]};
      num_v = num_v << 1;
      if (t_v >= {1'b0, dvs}) begin
        drem_v   = DIV_BITS'(t_v - {1'b0, dvs});
        num_v[0] = 1'b1;
      end else begin
        drem_v = DIV_BITS'(t_v);
      end
    end
    div_rem_nxt = drem_v;
    div_num_nxt = num_v;
  end

  // Clamp the quotient and apply the sign.
  assign q_wide  = WIDE_BITS'(num_r);
  assign sat_pos = q_wide > POS_MAX;
  assign sat_neg = q_wide > NEG_MAX;
  assign sat     = neg_r ? sat_neg : sat_pos;
  assign q_clamp = neg_r ? (sat_neg ? NEG_MAX : q_wide) : (sat_pos ? POS_MAX : q_wide);
  assign angle   = neg_r ? -ANGLE_BITS'(q_clamp) : ANGLE_BITS'(q_clamp);

  // Datapath registers, advanced by the phase strobes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r   <= '0;
      ay_r   <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      acc_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
      prev_r <= '0;
      dmag_r <= '0;
      neg_r  <= 1'b0;
      num_r  <= '0;
      drem_r <= '0;
    end else if (ctrl.load) begin
      ax_r   <= dx_mag;
      ay_r   <= dy_mag;
      sx_r   <= dx_mag;
      sy_r   <= dy_mag;
      acc_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctrl.sq_step) begin
      acc_r <= sq_nxt;
      sx_r  <= sx_r << 1;
      sy_r  <= sy_r << 1;
    end else if (ctrl.root_step) begin
      acc_r  <= acc_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end else if (ctrl.delta) begin
      dmag_r <= dmag_nxt;
      neg_r  <= neg_nxt;
      prev_r <= root_r;
    end else if (ctrl.scale) begin
      num_r  <= num_nxt;
      drem_r <= '0;
    end else if (ctrl.div_step) begin
      num_r  <= div_num_nxt;
      drem_r <= div_rem_nxt;
    end
  end

  // The square root remainder never exceeds twice the partial root.
  `ASSERT_NOW(a_root_rem_bound, ctrl.root_step, rem_r <= REM_BITS'({root_r, 1'b0}))
  // The division remainder stays below the divisor.
  `ASSERT_NOW(a_div_rem_bound, ctrl.div_step, drem_r < dvs)

endmodule

FILE: rtl/core/cable_length_to_angle_delta.sv
// Inverse kinematics for a two-cable plotter. Each point request (1/16 mm)
// gives the exact floor square root of the squared distance to each anchor
// (anchor register plus the trajectory origin), and turns the change since
// the previous point into angles -100*dL/r (left) and +100*dL/r (right),
// rounded to nearest with ties away from zero, with ANGLE_FRACTION_BITS
// fraction bits, clamped to 32 bits with saturated set. A point flagged
// first_point becomes the new origin, sets the previous lengths and gives
// zero angles. A radius of 0 acts as 1. Both cables are worked in parallel
// lanes; a point passes through bit-serial squaring, a square root that
// yields one root bit per cycle, the length change, scaling and a divider
// that retires two quotient bits per cycle, and the result is registered
// once the output register is free. The next point can be accepted in the
// cycle after the result is registered, while that result may still wait
// at the output.
`include "assert_macros.svh"

module cable_length_to_angle_delta #(
  parameter int ANGLE_FRACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  cld_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cld_pkg::out_item_t                    out_data,
  input  logic                                  cfg_we,
  input  logic [cld_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [cld_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int SQ_STEPS   = cld_pkg::MAG_BITS;
  localparam int ROOT_STEPS = cld_pkg::LEN_BITS;
  localparam int DIV_STEPS  = cld_pkg::div_cycles(ANGLE_FRACTION_BITS);
  localparam int MAX_A      = (SQ_STEPS > ROOT_STEPS) ? SQ_STEPS : ROOT_STEPS;
  localparam int MAX_STEPS  = (MAX_A > DIV_STEPS) ? MAX_A : DIV_STEPS;
  localparam int CNT_BITS   = $clog2(MAX_STEPS);
  localparam int COORD_BITS = cld_pkg::COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT,
    S_DELTA,
    S_SCALE,
    S_DIVIDE,
    S_WRITE
  } state_t;

  state_t                           state_r;
  logic [CNT_BITS-1:0]              cnt_r;
  logic signed [COORD_BITS-1:0]     origin_x_r, origin_y_r;
  logic signed [COORD_BITS-1:0]     left_x_r, left_y_r, right_x_r, right_y_r;
  logic [cld_pkg::RADIUS_BITS-1:0]  radius_r, radius_eff;
  logic                             first_r;
  logic                             out_valid_r;
  cld_pkg::out_item_t               out_data_r;
  logic                             accept, out_free;
  logic signed [COORD_BITS-1:0]     org_x, org_y;
  logic signed [cld_pkg::DIFF_BITS-1:0] ldx, ldy, rdx, rdy;
  cld_pkg::lane_ctrl_t              ctrl;
  logic signed [cld_pkg::ANGLE_BITS-1:0] left_angle, right_angle;
  logic                             left_sat, right_sat;

  assign in_ready  = state_r == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign radius_eff = (radius_r == '0) ? cld_pkg::RADIUS_BITS'(1) : radius_r;

  // A first point is its own origin.
  assign org_x = in_data.first_point ? in_data.point_x : origin_x_r;
  assign org_y = in_data.first_point ? in_data.point_y : origin_y_r;

  // Offsets from each anchor.
  assign ldx = cld_pkg::sext_coord(in_data.point_x) - cld_pkg::sext_coord(org_x)
             - cld_pkg::sext_coord(left_x_r);
  assign ldy = cld_pkg::sext_coord(in_data.point_y) - cld_pkg::sext_coord(org_y)
             - cld_pkg::sext_coord(left_y_r);
  assign rdx = cld_pkg::sext_coord(in_data.point_x) - cld_pkg::sext_coord(org_x)
             - cld_pkg::sext_coord(right_x_r);
  assign rdy = cld_pkg::sext_coord(in_data.point_y) - cld_pkg::sext_coord(org_y)
             - cld_pkg::sext_coord(right_y_r);

  // Phase strobes for the lanes.
  always_comb begin
    ctrl           = '0;
    ctrl.load      = accept;
    ctrl.sq_step   = state_r == S_SQUARE;
    ctrl.root_step = state_r == S_ROOT;
    ctrl.delta     = state_r == S_DELTA;
    ctrl.scale     = state_r == S_SCALE;
    ctrl.div_step  = state_r == S_DIVIDE;
  end

  // The left angle carries the opposite sign of the length change.
  cld_lane #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .flip   (1'b1),
    .dx     (ldx),
    .dy     (ldy),
    .radius (radius_eff),
    .angle  (left_angle),
    .sat    (left_sat)
  );

  cld_lane #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .flip   (1'b0),
    .dx     (rdx),
    .dy     (rdy),
    .radius (radius_eff),
    .angle  (right_angle),
    .sat    (right_sat)
  );

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_x_r  <= cld_pkg::LEFT_X_RESET;
      left_y_r  <= cld_pkg::LEFT_Y_RESET;
      right_x_r <= cld_pkg::RIGHT_X_RESET;
      right_y_r <= cld_pkg::RIGHT_Y_RESET;
      radius_r  <= cld_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      case (cld_pkg::cfg_reg_t'(cfg_index))
        cld_pkg::CFG_LEFT_X:  left_x_r  <= cfg_data;
        cld_pkg::CFG_LEFT_Y:  left_y_r  <= cfg_data;
        cld_pkg::CFG_RIGHT_X: right_x_r <= cfg_data;
        cld_pkg::CFG_RIGHT_Y: right_y_r <= cfg_data;
        cld_pkg::CFG_RADIUS:  radius_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, trajectory origin and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      // A result taken while a new one is written is replaced below.
      if (out_valid_r && out_ready && state_r != S_WRITE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            first_r <= in_data.first_point;
            if (in_data.first_point) begin
              origin_x_r <= in_data.point_x;
              origin_y_r <= in_data.point_y;
            end
            cnt_r   <= CNT_BITS'(SQ_STEPS - 1);
            state_r <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (cnt_r == '0) begin
            cnt_r   <= CNT_BITS'(ROOT_STEPS - 1);
            state_r <= S_ROOT;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_ROOT: begin
          if (cnt_r == '0) begin
            state_r <= S_DELTA;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_DELTA: begin
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          cnt_r   <= CNT_BITS'(DIV_STEPS - 1);
          state_r <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (cnt_r == '0) begin
            state_r <= S_WRITE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (first_r) begin
              out_data_r <= '0;
            end else begin
              out_data_r.left_angle  <= left_angle;
              out_data_r.right_angle <= right_angle;
              out_data_r.saturated   <= left_sat || right_sat;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A new request always starts a full squaring pass.
  `ASSERT_NEXT(a_accept_starts, accept, state_r == S_SQUARE && cnt_r == CNT_BITS'(SQ_STEPS - 1))
  // The divider is not left before its last step.
  `ASSERT_NEXT(a_divide_length, state_r == S_DIVIDE && cnt_r != '0, state_r == S_DIVIDE)
  // A first point always reports zero angles without saturation.
  `ASSERT_NEXT(a_first_zero, state_r == S_WRITE && out_free && first_r, out_valid_r && out_data_r.left_angle == '0 && out_data_r.right_angle == '0 && !out_data_r.saturated)

endmodule
